// File: rtl/sbs_pkg.sv
// Shared types and constants for the sample block statistics unit.
`timescale 1ns / 1ps

package sbs_pkg;

  localparam int unsigned SampleW = 16;

  typedef logic signed [SampleW-1:0] sample_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SHIFT  = 6'b000010,
    ST_PLACE  = 6'b000100,
    ST_FETCH  = 6'b001000,
    ST_MEDIAN = 6'b010000,
    ST_DIV    = 6'b100000
  } state_e;

endpackage

// File: rtl/sample_block_statistics_top.sv
// Block min/max/mean/median of Q8.8 samples: insertion sort in RAM, reciprocal-multiply mean.
//
//   channel  | handshake                       | payload
//   ---------+---------------------------------+---------------------------------------
//   sample   | sample_valid_i / sample_ready_o | sample_i
//   result   | result_valid_o / result_ready_i | max_temp_o min_temp_o mean_temp_o
//            |                                 | median_temp_o
//
// A sample is insertion-sorted into the sample RAM, one entry moved per cycle over its single
// read and write port. The batch's last sample adds RAM reads of max, min and both middle
// entries, a median step and a mean step that multiplies by the reciprocal of BLOCK_SIZE.
// rst_ni clears the fill count, the sum and both handshakes; the RAM needs no clear.
// A result waits in the output register while the next batch loads; if it is still
// there when the following batch completes, the sequencer stalls until it is taken.
`timescale 1ns / 1ps

module sample_block_statistics_top #(
  parameter int unsigned BLOCK_SIZE = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             sample_valid_i,
  output logic             sample_ready_o,
  input  sbs_pkg::sample_t sample_i,
  output logic             result_valid_o,
  input  logic             result_ready_i,
  output sbs_pkg::sample_t max_temp_o,
  output sbs_pkg::sample_t min_temp_o,
  output sbs_pkg::sample_t mean_temp_o,
  output sbs_pkg::sample_t median_temp_o
);

  import sbs_pkg::*;

  localparam int unsigned AW     = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam int unsigned CNT_W  = $clog2(BLOCK_SIZE + 1);
  // biased sum (each sample offset by half scale) stays below BLOCK_SIZE * 2^16
  localparam int unsigned SUM_W  = SampleW + $clog2(BLOCK_SIZE + 1);
  // floor(n / BLOCK_SIZE) == (n * RecMul) >> RecShift for every n below 2^SUM_W
  localparam int unsigned RecShift = SUM_W + $clog2(BLOCK_SIZE);
  localparam int unsigned MUL_W    = SUM_W + 2;
  localparam int unsigned PROD_W   = SUM_W + MUL_W;

  localparam logic [AW-1:0]    IdxMax  = AW'(BLOCK_SIZE - 1);
  localparam logic [AW-1:0]    IdxMin  = '0;
  localparam logic [AW-1:0]    IdxLo   = AW'((BLOCK_SIZE - 1) / 2);
  localparam logic [AW-1:0]    IdxHi   = AW'(BLOCK_SIZE / 2);
  localparam logic [CNT_W-1:0] LastCnt = CNT_W'(BLOCK_SIZE - 1);
  localparam logic [MUL_W-1:0] RecMul  =
      MUL_W'(((64'd1 << RecShift) + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE));

  state_e state_q, state_d;

  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [2:0]        step_q, step_d;
  logic              out_valid_q, out_valid_d;

  sample_t          x_q, x_d;
  sample_t          max_q, max_d;
  sample_t          min_q, min_d;
  sample_t          lo_q, lo_d;
  sample_t          med_q, med_d;
  logic [SUM_W-1:0] dvd_q, dvd_d;
  sample_t          max_out_q, max_out_d;
  sample_t          min_out_q, min_out_d;
  sample_t          mean_out_q, mean_out_d;
  sample_t          med_out_q, med_out_d;

  // sample RAM
  sample_t         mem_q [BLOCK_SIZE];
  sample_t         rd_q;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  sample_t         mem_wd;
  logic [AW-1:0]   mem_ra;

  logic               accept;
  logic [PROD_W-1:0]  mean_prod;
  logic [SampleW-1:0] mean_quo;
  logic [SampleW:0]   pair_sum;

  assign accept         = sample_valid_i && sample_ready_o;
  assign sample_ready_o = (state_q == ST_IDLE);
  assign result_valid_o = out_valid_q;
  assign max_temp_o     = max_out_q;
  assign min_temp_o     = min_out_q;
  assign mean_temp_o    = mean_out_q;
  assign median_temp_o  = med_out_q;

  assign mean_prod = PROD_W'(dvd_q) * PROD_W'(RecMul);
  assign mean_quo  = mean_prod[RecShift +: SampleW];
  assign pair_sum  = {lo_q[SampleW-1], lo_q} + {rd_q[SampleW-1], rd_q};

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    pos_d       = pos_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    x_d         = x_q;
    max_d       = max_q;
    min_d       = min_q;
    lo_d        = lo_q;
    med_d       = med_q;
    dvd_d       = dvd_q;
    max_out_d   = max_out_q;
    min_out_d   = min_out_q;
    mean_out_d  = mean_out_q;
    med_out_d   = med_out_q;
    mem_we      = 1'b0;
    mem_wa      = pos_q;
    mem_wd      = x_q;
    mem_ra      = pos_q - AW'(1);

    if (out_valid_q && result_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          x_d   = sample_i;
          // offset binary: sample + half scale, so the sum stays unsigned
          sum_d = sum_q + SUM_W'({~sample_i[SampleW-1], sample_i[SampleW-2:0]});
          pos_d = fill_q[AW-1:0];
          if (fill_q == '0) begin
            state_d = ST_PLACE;
          end else begin
            mem_ra  = fill_q[AW-1:0] - AW'(1);
            state_d = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        // rd_q holds entry pos-1 of the sorted prefix
        mem_we = 1'b1;
        if (rd_q > x_q) begin
          mem_wd = rd_q;
          pos_d  = pos_q - AW'(1);
          mem_ra = pos_q - AW'(2);
          if (pos_q == AW'(1)) begin
            state_d = ST_PLACE;
          end
        end else begin
          mem_wd = x_q;
          if (fill_q == LastCnt) begin
            fill_d  = '0;
            step_d  = '0;
            state_d = ST_FETCH;
          end else begin
            fill_d  = fill_q + CNT_W'(1);
            state_d = ST_IDLE;
          end
        end
      end
      ST_PLACE: begin
        mem_we = 1'b1;
        mem_wd = x_q;
        if (fill_q == LastCnt) begin
          fill_d  = '0;
          step_d  = '0;
          state_d = ST_FETCH;
        end else begin
          fill_d  = fill_q + CNT_W'(1);
          state_d = ST_IDLE;
        end
      end
      ST_FETCH: begin
        // read max, min, lower and upper middle; each word lands in the next cycle
        case (step_q)
          3'd0:    mem_ra = IdxMax;
          3'd1:    mem_ra = IdxMin;
          3'd2:    mem_ra = IdxLo;
          default: mem_ra = IdxHi;
        endcase
        case (step_q)
          3'd1:    max_d = rd_q;
          3'd2:    min_d = rd_q;
          default: lo_d  = (step_q == 3'd3) ? rd_q : lo_q;
        endcase
        step_d = step_q + 3'd1;
        if (step_q == 3'd3) begin
          state_d = ST_MEDIAN;
        end
      end
      ST_MEDIAN: begin
        // odd sizes read the centre twice, so the floored average is exact
        med_d   = pair_sum[SampleW:1];
        dvd_d   = sum_q;
        sum_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!out_valid_q || result_ready_i) begin
          out_valid_d = 1'b1;
          max_out_d   = max_q;
          min_out_d   = min_q;
          // undo the half-scale bias folded into the quotient
          mean_out_d  = {~mean_quo[SampleW-1], mean_quo[SampleW-2:0]};
          med_out_d   = med_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      sum_q       <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      pos_q       <= pos_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    max_q      <= max_d;
    min_q      <= min_d;
    lo_q       <= lo_d;
    med_q      <= med_d;
    dvd_q      <= dvd_d;
    max_out_q  <= max_out_d;
    min_out_q  <= min_out_d;
    mean_out_q <= mean_out_d;
    med_out_q  <= med_out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

endmodule

// File: verif/tb_sample_block_statistics_top.sv
// Self-checking testbench for sample_block_statistics_top: a directed batch, then random traffic with a scoreboard.
`timescale 1ns / 1ps

module tb_sample_block_statistics_top;
  import sbs_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int BlockSize     = 16;
  localparam int SumW          = SampleW + $clog2(BlockSize);
  localparam int RandomBatches = 125;
  localparam int SettleCycles  = 100;
  localparam int WatchdogLimit = 3000;

  typedef struct {
    sample_t value;
    bit      drain_first;  // hold this item until every pending result has come back
  } feed_item_t;

  typedef struct {
    sample_t max_v;
    sample_t min_v;
    sample_t mean_v;
    sample_t median_v;
  } batch_stats_t;

  logic    clk_i          = 1'b0;
  logic    rst_ni         = 1'b0;
  logic    sample_valid_i = 1'b0;
  logic    sample_ready_o;
  sample_t sample_i       = '0;
  logic    result_valid_o;
  logic    result_ready_i = 1'b0;
  sample_t max_temp_o;
  sample_t min_temp_o;
  sample_t mean_temp_o;
  sample_t median_temp_o;

  feed_item_t   feed_q[$];
  batch_stats_t batch_stats_q[$];

  // running batch state of the predictor
  sample_t                batch_vals[BlockSize];
  int unsigned            batch_fill = 0;
  logic signed [SumW-1:0] batch_sum  = '0;

  bit          in_accepted  = 1'b0;
  bit          out_accepted = 1'b0;
  int unsigned in_gap       = 0;
  int unsigned out_gap      = 0;
  int unsigned in_calm      = 0;
  int unsigned out_calm     = 0;
  int unsigned idle_cycles  = 0;
  int unsigned samples_in   = 0;
  int unsigned results_seen = 0;
  int unsigned drains_done  = 0;
  int unsigned full_scale_batches = 0;
  int unsigned mismatch_count     = 0;

  sample_block_statistics_top #(
    .BLOCK_SIZE(BlockSize)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .max_temp_o     (max_temp_o),
    .min_temp_o     (min_temp_o),
    .mean_temp_o    (mean_temp_o),
    .median_temp_o  (median_temp_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int unsigned draw_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) calm = $urandom_range(30, 120);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Adds one sample to the batch; on the batch's last sample computes the statistics.
  task automatic absorb_sample(input sample_t s);
    sample_t      sorted[BlockSize];
    sample_t      x;
    int           j;
    int           total;
    int           q;
    int           pair;
    batch_stats_t st;
    batch_vals[batch_fill] = s;
    batch_sum += s;
    batch_fill++;
    if (batch_fill < BlockSize) return;

    for (int i = 0; i < BlockSize; i++) begin
      x = batch_vals[i];
      j = i;
      while (j > 0 && sorted[j-1] > x) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = x;
    end

    total = int'(batch_sum);
    q = total / BlockSize;
    if ((total % BlockSize) != 0 && total < 0) q--;  // round toward minus infinity

    if (BlockSize % 2 == 0) begin
      pair = int'(sorted[BlockSize/2 - 1]) + int'(sorted[BlockSize/2]);
      st.median_v = sample_t'(pair >>> 1);
    end else begin
      st.median_v = sorted[BlockSize/2];
    end
    st.max_v  = sorted[BlockSize-1];
    st.min_v  = sorted[0];
    st.mean_v = sample_t'(q);
    batch_stats_q = {batch_stats_q, st};
    batch_fill = 0;
    batch_sum  = '0;
  endtask

  task automatic compare_field(input string name, input sample_t exp_v, input sample_t act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic add_batch(input int unsigned mode, input bit drain_first);
    feed_item_t item;
    sample_t    picks[3];
    for (int k = 0; k < 3; k++) picks[k] = sample_t'($urandom_range(0, 65535));
    if (mode == 1 || mode == 2) full_scale_batches++;
    for (int i = 0; i < BlockSize; i++) begin
      case (mode)
        1:       item.value = 16'sh7fff;
        2:       item.value = -16'sh8000;
        3:       item.value = sample_t'(int'($urandom_range(0, 16)) - 8);
        4:       item.value = $urandom_range(0, 1) ? sample_t'(32767 - $urandom_range(0, 7))
                                                   : sample_t'(-32768 + $urandom_range(0, 7));
        5:       item.value = picks[$urandom_range(0, 2)];
        default: item.value = sample_t'($urandom_range(0, 65535));
      endcase
      item.drain_first = (i == 0) ? drain_first : ($urandom_range(0, 299) == 0);
      feed_q = {feed_q, item};
    end
  endtask

  // Sample side driver: holds valid and payload until the item is taken.
  always @(negedge clk_i) begin : drive_samples
    feed_item_t item;
    logic       next_valid;
    if (rst_ni && !(sample_valid_i && !in_accepted)) begin
      next_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (feed_q.size() > 0 &&
                   (!feed_q[0].drain_first || batch_stats_q.size() == 0)) begin
        item = feed_q.pop_front();
        if (item.drain_first) drains_done++;
        sample_i   <= item.value;
        next_valid  = 1'b1;
        in_gap      = draw_gap(in_calm);
      end
      sample_valid_i <= next_valid;
    end
  end

  always @(negedge clk_i) begin : drive_result_ready
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap--;
        result_ready_i <= 1'b0;
      end else begin
        result_ready_i <= 1'b1;
        if ($urandom_range(0, 5) == 0) out_gap = draw_gap(out_calm);
      end
    end
  end

  // Monitor, scoreboard and watchdog
  always @(posedge clk_i) begin : monitor
    batch_stats_t exp_st;
    in_accepted  = rst_ni && sample_valid_i && sample_ready_o;
    out_accepted = rst_ni && result_valid_o && result_ready_i;

    if (out_accepted) begin
      results_seen++;
      if (batch_stats_q.size() == 0) begin
        $error("result item with no batch pending: max %0d min %0d mean %0d median %0d",
               max_temp_o, min_temp_o, mean_temp_o, median_temp_o);
        mismatch_count++;
      end else begin
        exp_st = batch_stats_q.pop_front();
        compare_field("max_temp", exp_st.max_v, max_temp_o);
        compare_field("min_temp", exp_st.min_v, min_temp_o);
        compare_field("mean_temp", exp_st.mean_v, mean_temp_o);
        compare_field("median_temp", exp_st.median_v, median_temp_o);
      end
    end

    if (in_accepted) begin
      samples_in++;
      absorb_sample(sample_i);
    end

    if (in_accepted || out_accepted) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no item moved for %0d cycles", idle_cycles);
      $display("tb_sample_block_statistics_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    feed_item_t   item;
    sample_t      directed_vals[BlockSize];
    int unsigned  r;
    int unsigned  mode;

    // one hand-picked batch: both rails, values around zero, duplicates, odd fractions
    directed_vals = '{16'sh7fff, -16'sh8000, -16'sh0001, 16'sh0000,
                      16'sh0001, -16'sh8000, 16'sh7fff, 16'sh1900,
                      -16'sh0a00, 16'sh0080, -16'sh0003, 16'sh0007,
                      -16'sh7fff, 16'sh7ffe, 16'sh0064, -16'sh0065};
    foreach (directed_vals[i]) begin
      item.value       = directed_vals[i];
      item.drain_first = 1'b0;
      feed_q = {feed_q, item};
    end

    // first random batch waits until the directed result is back
    for (int b = 0; b < RandomBatches; b++) begin
      r = $urandom_range(0, 99);
      if (r < 50)      mode = 0;
      else if (r < 58) mode = 1;
      else if (r < 66) mode = 2;
      else if (r < 78) mode = 3;
      else if (r < 88) mode = 4;
      else             mode = 5;
      add_batch(mode, (b == 0) || ($urandom_range(0, 29) == 0));
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (feed_q.size() > 0 || sample_valid_i) @(posedge clk_i);
    while (batch_stats_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d samples in %0d checked batch results (%0d full-scale batches)",
             samples_in, results_seen, full_scale_batches);
    $display("sender drained the result path %0d times under random stalls on both sides",
             drains_done);
    if (mismatch_count == 0) begin
      $display("tb_sample_block_statistics_top: done, clean");
    end else begin
      $display("tb_sample_block_statistics_top: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sbs_pkg.sv
rtl/sample_block_statistics_top.sv
verif/tb_sample_block_statistics_top.sv
